// File: src/absis_pkg.sv
// ----------------------------------------------------------------------------
// absis_pkg: shared types and constants for the array search tree unit
// Status codes, sequencer states and the result record passed to the top level.
// ----------------------------------------------------------------------------
package absis_pkg;

  localparam int LEVELS_DEF = 7;
  localparam int KEY_W      = 32;
  localparam int POS_W      = 7;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_WALK  = 2'd2
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  position;
  } res_t;

endpackage

// File: src/absis_ram.sv
// ----------------------------------------------------------------------------
// absis_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module absis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/absis_walk.sv
// ----------------------------------------------------------------------------
// absis_walk: tree walk sequencer
// Clears the slot table after reset, then walks one tree level per cycle,
// comparing the item key with the slot read from the key RAM.
// ----------------------------------------------------------------------------
module absis_walk #(
  parameter int LEVELS = absis_pkg::LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_search,
  input  logic [absis_pkg::KEY_W-1:0]   in_key,
  output logic                          res_valid,
  input  logic                          res_ready,
  output absis_pkg::res_t               res
);

  localparam int IW    = LEVELS;
  localparam int SLOTS = (1 << LEVELS) - 1;
  localparam int KW    = absis_pkg::KEY_W;
  localparam int PW    = absis_pkg::POS_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [IW-1:0] LAST_BASE = IW'((32'd1 << (LEVELS - 1)) - 32'd1);

  absis_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        clr_r, clr_nxt;
  logic signed [KW-1:0] key_r, key_nxt;
  logic                 search_r, search_nxt;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [KW:0]          ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [KW:0]          ram_rdata;

  logic                 slot_vld;
  logic signed [KW-1:0] slot_key;
  logic                 key_lt;
  logic                 key_eq;
  logic [IW-1:0]        child;

  absis_ram #(
    .WIDTH (KW + 1),
    .DEPTH (SLOTS)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_vld = ram_rdata[KW];
  assign slot_key = ram_rdata[KW-1:0];
  assign key_lt   = key_r < slot_key;
  assign key_eq   = key_r == slot_key;
  assign child    = (idx_r << 1) + IW'(key_lt ? 2'd1 : 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= absis_pkg::S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    key_r    <= key_nxt;
    search_r <= search_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    idx_nxt      = idx_r;
    key_nxt      = key_r;
    search_nxt   = search_r;
    ram_we       = 1'b0;
    ram_waddr    = clr_r;
    ram_wdata    = '0;
    ram_raddr    = '0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    res.status   = absis_pkg::ST_NOT_FOUND;
    res.position = '0;

    unique case (state_r)
      absis_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_r == LAST_SLOT) begin
          state_nxt = absis_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      absis_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt    = in_key;
          search_nxt = in_search;
          idx_nxt    = '0;
          state_nxt  = absis_pkg::S_WALK;
        end
      end
      absis_pkg::S_WALK: begin
        ram_raddr = idx_r;
        if (!slot_vld) begin
          res_valid = 1'b1;
          if (search_r) begin
            res.status = absis_pkg::ST_NOT_FOUND;
          end else begin
            res.status   = absis_pkg::ST_INSERTED;
            res.position = PW'(idx_r);
            ram_we       = res_ready;
            ram_waddr    = idx_r;
            ram_wdata    = {1'b1, key_r};
          end
        end else if (key_eq) begin
          res_valid = 1'b1;
          if (search_r) begin
            res.status   = absis_pkg::ST_FOUND;
            res.position = PW'(idx_r);
          end else begin
            res.status = absis_pkg::ST_DUPLICATE;
          end
        end else if (idx_r >= LAST_BASE) begin
          res_valid  = 1'b1;
          res.status = search_r ? absis_pkg::ST_NOT_FOUND : absis_pkg::ST_NO_ROOM;
        end else begin
          idx_nxt   = child;
          ram_raddr = child;
        end
        if (res_valid && res_ready) begin
          state_nxt = absis_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = absis_pkg::S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

endmodule

// File: src/array_bst_insert_search_unit.sv
// ----------------------------------------------------------------------------
// array_bst_insert_search_unit: binary search tree kept in an implicit array
// Inserts or looks up signed 32-bit keys; slot i has children 2i+1 and 2i+2.
// ----------------------------------------------------------------------------
// An item walks the tree from the root one level per cycle, a pace set by the
// single read port of the key RAM. After reset the block clears the slot
// table, one slot a cycle, all 2^LEVELS - 1 slots (127 at the default of
// seven levels), and accepts no transfer until that is done. A finished
// result waits in an output register, so a new item can be taken while the
// previous result is still pending.
module array_bst_insert_search_unit #(
  parameter int LEVELS = absis_pkg::LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] position, [7] zero
  output logic [2:0]  out_tuser   // [2:0] status
);

  logic            res_valid;
  logic            res_ready;
  absis_pkg::res_t res;
  logic            out_tvalid_r;
  absis_pkg::res_t out_res_r;

  absis_walk #(
    .LEVELS (LEVELS)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_search (in_tuser[0]),
    .in_key    (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_res_r.position};
  assign out_tuser  = out_res_r.status;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted transfer");

  a_result_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("result raised while the walk is idle");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("stalled walk result changed");

  a_zero_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == absis_pkg::ST_DUPLICATE ||
                    out_tuser == absis_pkg::ST_NO_ROOM ||
                    out_tuser == absis_pkg::ST_NOT_FOUND)) |-> (out_tdata == 8'd0))
    else $error("nonzero position with a miss status");
`endif

endmodule
